/* hdl/spi_pkg.sv */
// Shared widths and the division pipeline payload type for the segment/plane intersection block.
package spi_pkg;

    // Coordinate format.
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 31;

    // Derived arithmetic widths.
    localparam int DIFF_W = COORD_W + 1;       // end - start, plane - start
    localparam int UMAG_W = COORD_W;           // magnitude of a difference
    localparam int PROD_W = DIFF_W + COORD_W;  // one normal component times one difference
    localparam int SUM_W  = PROD_W + 2;        // sum of three products
    localparam int MAG_W  = SUM_W;             // magnitude of d or n
    localparam int REM_W  = MAG_W + 2;         // running remainder, below three times d
    localparam int LANES  = 3;

    // Payload carried through each step of the multiply-divide chain.
    typedef struct packed {
        logic                                miss;
        logic [LANES-1:0]                    uneg;
        logic [MAG_W-1:0]                    den;
        logic [MAG_W-1:0]                    num;
        logic [LANES-1:0][UMAG_W-1:0]        umag;
        logic [LANES-1:0][REM_W-1:0]         rem;
        logic [LANES-1:0][UMAG_W-1:0]        quo;
        logic [LANES-1:0][COORD_W-1:0]       p0;
    } div_beat_t;

endpackage

/* hdl/segment_plane_intersection.sv */
// Top level of the segment/plane intersection pipeline.
// Accepts one segment/plane query per clock while no result beat is held at the output, and
// returns one result beat per query, in order. Register stages form the differences, the six
// products, the two dot-product sums and the miss tests in turn; then a chain of step stages
// works through |end - start| one bit at a time to form u*n/d for all three axes, and a final
// output register adds the offset to the start point. While the output beat is stalled the
// whole pipeline holds; the configuration port is always ready and its tolerance is used in
// the fourth stage.
module segment_plane_intersection (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [spi_pkg::COORD_W-1:0]   start_x,
    input  logic signed [spi_pkg::COORD_W-1:0]   start_y,
    input  logic signed [spi_pkg::COORD_W-1:0]   start_z,
    input  logic signed [spi_pkg::COORD_W-1:0]   end_x,
    input  logic signed [spi_pkg::COORD_W-1:0]   end_y,
    input  logic signed [spi_pkg::COORD_W-1:0]   end_z,
    input  logic signed [spi_pkg::COORD_W-1:0]   plane_x,
    input  logic signed [spi_pkg::COORD_W-1:0]   plane_y,
    input  logic signed [spi_pkg::COORD_W-1:0]   plane_z,
    input  logic signed [spi_pkg::COORD_W-1:0]   normal_x,
    input  logic signed [spi_pkg::COORD_W-1:0]   normal_y,
    input  logic signed [spi_pkg::COORD_W-1:0]   normal_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic signed [spi_pkg::COORD_W-1:0]   hit_x,
    output logic signed [spi_pkg::COORD_W-1:0]   hit_y,
    output logic signed [spi_pkg::COORD_W-1:0]   hit_z,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spi_pkg::TOL_W-1:0]            cfg_data
);
    import spi_pkg::*;

    logic                           adv;
    logic [TOL_W-1:0]               tol_reg;
    logic [LANES-1:0][COORD_W-1:0]  start_p, end_p, plane_p, normal_p;
    logic                           chain_valid [UMAG_W+1];
    div_beat_t                      chain_beat  [UMAG_W+1];
    logic                           out_valid_reg;
    logic                           hit_reg;
    logic [LANES-1:0][COORD_W-1:0]  coord_reg, coord_next;

    // The pipeline moves unless a finished beat is held at the output.
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    assign start_p  = {start_z, start_y, start_x};
    assign end_p    = {end_z, end_y, end_x};
    assign plane_p  = {plane_z, plane_y, plane_x};
    assign normal_p = {normal_z, normal_y, normal_x};

    spi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .start_p  (start_p),
        .end_p    (end_p),
        .plane_p  (plane_p),
        .normal_p (normal_p),
        .tol      (tol_reg),
        .out_valid(chain_valid[0]),
        .out_beat (chain_beat[0])
    );

    // One step stage for each bit of |u|.
    for (genvar i = 0; i < UMAG_W; i++)
    begin : g_step
        spi_div_stage u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_valid (chain_valid[i]),
            .in_beat  (chain_beat[i]),
            .out_valid(chain_valid[i+1]),
            .out_beat (chain_beat[i+1])
        );
    end

    // Intersection point: start plus the signed offset; zero on a miss.
    always_comb
    begin
        logic [COORD_W-1:0] off;
        for (int k = 0; k < LANES; k++)
        begin
            off = chain_beat[UMAG_W].uneg[k] ? (~chain_beat[UMAG_W].quo[k] + 1'b1)
                                             : chain_beat[UMAG_W].quo[k];
            coord_next[k] = chain_beat[UMAG_W].miss ? '0 : (chain_beat[UMAG_W].p0[k] + off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[UMAG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg   <= !chain_beat[UMAG_W].miss;
            coord_reg <= coord_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = coord_reg[0];
    assign hit_y     = coord_reg[1];
    assign hit_z     = coord_reg[2];

endmodule

/* hdl/spi_front.sv */
// Front end: differences, dot products and hit classification over four register stages.
module spi_front (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           adv,
    input  logic                                           in_valid,
    input  logic [spi_pkg::LANES-1:0][spi_pkg::COORD_W-1:0] start_p,
    input  logic [spi_pkg::LANES-1:0][spi_pkg::COORD_W-1:0] end_p,
    input  logic [spi_pkg::LANES-1:0][spi_pkg::COORD_W-1:0] plane_p,
    input  logic [spi_pkg::LANES-1:0][spi_pkg::COORD_W-1:0] normal_p,
    input  logic [spi_pkg::TOL_W-1:0]                      tol,
    output logic                                           out_valid,
    output spi_pkg::div_beat_t                             out_beat
);
    import spi_pkg::*;

    logic                                  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [LANES-1:0][DIFF_W-1:0]   s1_u_reg, s1_w_reg;
    logic [LANES-1:0][COORD_W-1:0]         s1_nrm_reg, s1_p0_reg;
    logic signed [LANES-1:0][PROD_W-1:0]   s2_pu_reg, s2_pw_reg;
    logic signed [LANES-1:0][DIFF_W-1:0]   s2_u_reg, s3_u_reg;
    logic [LANES-1:0][COORD_W-1:0]         s2_p0_reg, s3_p0_reg;
    logic signed [SUM_W-1:0]               s3_d_reg, s3_n_reg;
    div_beat_t                             s4_beat_reg, s4_beat_next;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stages one to three: differences, products, then the two dot-product sums.
    // Elements of a packed array read back as unsigned, so each is re-signed before widening.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s1_u_reg[k]   <= DIFF_W'(signed'(end_p[k]))   - DIFF_W'(signed'(start_p[k]));
                s1_w_reg[k]   <= DIFF_W'(signed'(plane_p[k])) - DIFF_W'(signed'(start_p[k]));
                s1_nrm_reg[k] <= normal_p[k];
                s1_p0_reg[k]  <= start_p[k];
                s2_pu_reg[k]  <= PROD_W'(signed'(s1_nrm_reg[k])) * PROD_W'(signed'(s1_u_reg[k]));
                s2_pw_reg[k]  <= PROD_W'(signed'(s1_nrm_reg[k])) * PROD_W'(signed'(s1_w_reg[k]));
            end
            s2_u_reg  <= s1_u_reg;
            s2_p0_reg <= s1_p0_reg;
            s3_d_reg  <= SUM_W'(signed'(s2_pu_reg[0])) + SUM_W'(signed'(s2_pu_reg[1]))
                       + SUM_W'(signed'(s2_pu_reg[2]));
            s3_n_reg  <= SUM_W'(signed'(s2_pw_reg[0])) + SUM_W'(signed'(s2_pw_reg[1]))
                       + SUM_W'(signed'(s2_pw_reg[2]));
            s3_u_reg  <= s2_u_reg;
            s3_p0_reg <= s2_p0_reg;
            s4_beat_reg <= s4_beat_next;
        end
    end

    // Stage four: magnitudes and the miss tests, which need no division.
    always_comb
    begin
        logic [SUM_W-1:0]  dabs;
        logic [SUM_W-1:0]  nabs;
        logic [DIFF_W-1:0] uabs;
        logic              dneg;
        logic              nneg;
        dneg = s3_d_reg[SUM_W-1];
        nneg = s3_n_reg[SUM_W-1];
        dabs = dneg ? (~s3_d_reg + 1'b1) : s3_d_reg;
        nabs = nneg ? (~s3_n_reg + 1'b1) : s3_n_reg;
        s4_beat_next.den = dabs;
        s4_beat_next.num = nabs;
        s4_beat_next.miss = (dabs == '0)
                          || ((dabs >> FRAC_BITS) < MAG_W'(tol))
                          || ((nabs != '0) && (nneg != dneg))
                          || (nabs > dabs);
        for (int k = 0; k < LANES; k++)
        begin
            uabs = s3_u_reg[k][DIFF_W-1] ? (~s3_u_reg[k] + 1'b1) : s3_u_reg[k];
            s4_beat_next.uneg[k] = s3_u_reg[k][DIFF_W-1];
            s4_beat_next.umag[k] = uabs[UMAG_W-1:0];
            s4_beat_next.rem[k]  = '0;
            s4_beat_next.quo[k]  = '0;
            s4_beat_next.p0[k]   = s3_p0_reg[k];
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_beat  = s4_beat_reg;

endmodule

/* hdl/spi_div_stage.sv */
// One step of the combined multiply-divide: takes one bit of |u| and yields one quotient digit.
module spi_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  spi_pkg::div_beat_t in_beat,
    output logic               out_valid,
    output spi_pkg::div_beat_t out_beat
);
    import spi_pkg::*;

    logic      valid_reg;
    div_beat_t beat_reg, beat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    // Remainder stays below d, so 2r + n is below 3d and each digit is 0, 1 or 2.
    always_comb
    begin
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] one_d;
        logic [REM_W-1:0] two_d;
        beat_next = in_beat;
        one_d = REM_W'(in_beat.den);
        two_d = REM_W'({in_beat.den, 1'b0});
        for (int k = 0; k < LANES; k++)
        begin
            r2 = {in_beat.rem[k][REM_W-2:0], 1'b0}
               + (in_beat.umag[k][UMAG_W-1] ? REM_W'(in_beat.num) : REM_W'(0));
            beat_next.umag[k] = {in_beat.umag[k][UMAG_W-2:0], 1'b0};
            if (r2 >= two_d)
            begin
                beat_next.rem[k] = r2 - two_d;
                beat_next.quo[k] = {in_beat.quo[k][UMAG_W-2:0], 1'b0} + UMAG_W'(2);
            end
            else if (r2 >= one_d)
            begin
                beat_next.rem[k] = r2 - one_d;
                beat_next.quo[k] = {in_beat.quo[k][UMAG_W-2:0], 1'b0} + UMAG_W'(1);
            end
            else
            begin
                beat_next.rem[k] = r2;
                beat_next.quo[k] = {in_beat.quo[k][UMAG_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* hdl/spi_chk.sv */
// Port-level checker for the segment/plane intersection block, with its bind.
module spi_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          hit,
    input logic [spi_pkg::COORD_W-1:0]   hit_x,
    input logic [spi_pkg::COORD_W-1:0]   hit_y,
    input logic [spi_pkg::COORD_W-1:0]   hit_z,
    input logic                          cfg_ready
);
    // A held result beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_x)
                                   && $stable(hit_y) && $stable(hit_z))
        else $error("result beat changed while stalled");

    // A miss reports the origin.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
        else $error("miss with non-zero point");

    // Input back-pressure only ever comes from a held output beat.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // The tolerance register never refuses a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");
endmodule

bind segment_plane_intersection spi_chk u_spi_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit      (hit),
    .hit_x    (hit_x),
    .hit_y    (hit_y),
    .hit_z    (hit_z),
    .cfg_ready(cfg_ready)
);
